/* hdl/txfra_pkg.sv */
// ----------------------------------------------------------------------------
// txfra_pkg
// types and constants of the transmit frame ring allocator
// ----------------------------------------------------------------------------
package txfra_pkg;

  localparam int unsigned ACTION_W = 2;
  localparam int unsigned LENGTH_W = 12;
  localparam int unsigned OFFSET_W = 11;
  localparam int unsigned COUNT_W  = 4;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ENQUEUE = 2'd0,
    ACT_DONE    = 2'd1,
    ACT_REFUSE  = 2'd2,
    ACT_NOP     = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RETIRE,
    ST_START
  } state_e;

endpackage

/* hdl/tx_frame_ring_allocator.sv */
// ----------------------------------------------------------------------------
// tx_frame_ring_allocator
// transmit frame manager that places frames contiguously in a byte ring
// ----------------------------------------------------------------------------
// Each input beat is one event: an enqueue request, a transmit-done, a
// refused start or a no-op. Every event yields exactly one result beat
// carrying the placement, any frame start and the queue and ring status
// after the event. Frame descriptors live in a single-port-write,
// registered-read table of QUEUE_SLOTS entries; ring and queue pointers
// are registers. One event is handled at a time: the input is held while
// the event passes the execute state and, where a descriptor read is
// needed (retiring a frame, or starting a frame already queued), the
// retire and start states; a transmit-done may both retire a frame and
// start the next one. The result appears at the output register in the
// same cycle that the input is ready again. A new event is taken while
// the previous result still waits at the output register; its work
// begins once that result is taken.
// ----------------------------------------------------------------------------
module tx_frame_ring_allocator #(
  parameter int unsigned BUF_BYTES   = 2048,
  parameter int unsigned QUEUE_SLOTS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [txfra_pkg::ACTION_W-1:0]     action_i,
  input  logic [txfra_pkg::LENGTH_W-1:0]     frame_length_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               accepted_o,
  output logic [txfra_pkg::OFFSET_W-1:0]     write_offset_o,
  output logic                               start_valid_o,
  output logic [txfra_pkg::OFFSET_W-1:0]     start_offset_o,
  output logic [txfra_pkg::OFFSET_W-1:0]     start_length_o,
  output logic [txfra_pkg::COUNT_W-1:0]      queued_frames_o,
  output logic [txfra_pkg::OFFSET_W-1:0]     free_bytes_o
);

  localparam int unsigned AW = $clog2(BUF_BYTES);
  localparam int unsigned QW = $clog2(QUEUE_SLOTS);
  localparam int unsigned OW = txfra_pkg::OFFSET_W;
  localparam int unsigned CW = txfra_pkg::COUNT_W;

  function automatic logic [AW-1:0] ring_wrap(input logic [AW:0] s);
    if (s >= (AW+1)'(BUF_BYTES)) begin
      ring_wrap = AW'(s - (AW+1)'(BUF_BYTES));
    end else begin
      ring_wrap = AW'(s);
    end
  endfunction

  function automatic logic [QW-1:0] slot_next(input logic [QW-1:0] s);
    if (s == QW'(QUEUE_SLOTS - 1)) begin
      slot_next = '0;
    end else begin
      slot_next = s + QW'(1);
    end
  endfunction

  function automatic logic [QW-1:0] frames_queued(input logic [QW-1:0] h,
                                                  input logic [QW-1:0] t);
    if (h >= t) begin
      frames_queued = h - t;
    end else begin
      frames_queued = QW'({1'b0, h} + (QW+1)'(QUEUE_SLOTS) - {1'b0, t});
    end
  endfunction

  function automatic logic [AW-1:0] bytes_free(input logic [AW-1:0] h,
                                               input logic [AW-1:0] t);
    if (h >= t) begin
      bytes_free = AW'((AW+1)'(BUF_BYTES) - {1'b0, h - t} - (AW+1)'(1));
    end else begin
      bytes_free = t - h - AW'(1);
    end
  endfunction

  // descriptor table
  logic [2*AW-1:0] mem [QUEUE_SLOTS];
  logic            mem_we;
  logic [QW-1:0]   mem_waddr;
  logic [2*AW-1:0] mem_wdata;
  logic            mem_re;
  logic [QW-1:0]   mem_raddr;
  logic [2*AW-1:0] mem_rdata_q;
  logic [AW-1:0]   rd_off;
  logic [AW-1:0]   rd_len;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= mem[mem_raddr];
    end
  end

  assign rd_off = mem_rdata_q[2*AW-1:AW];
  assign rd_len = mem_rdata_q[AW-1:0];

  txfra_pkg::state_e  state_q, state_d;
  txfra_pkg::action_e act_q;
  logic [txfra_pkg::LENGTH_W-1:0] len_q;

  logic [QW-1:0] qhead_q, qhead_d, qtail_q, qtail_d;
  logic [AW-1:0] bhead_q, bhead_d, btail_q, btail_d;
  logic          sending_q, sending_d;

  logic          out_valid_q, out_valid_d;
  logic          acc_q, acc_d;
  logic [OW-1:0] woff_q, woff_d;
  logic          sv_q, sv_d;
  logic [OW-1:0] soff_q, soff_d;
  logic [OW-1:0] slen_q, slen_d;
  logic [CW-1:0] qcnt_q, qcnt_d;
  logic [OW-1:0] free_q, free_d;

  logic          out_free;
  logic          finish;
  logic          q_empty;
  logic          q_full;
  logic          len_ok;
  logic [AW-1:0] len_a;
  logic [AW:0]   room;
  logic [AW:0]   need;
  logic          fits;
  logic [AW-1:0] at;

  assign in_ready_o = (state_q == txfra_pkg::ST_IDLE);
  assign out_free   = !out_valid_q || out_ready_i;
  assign q_empty    = (qhead_q == qtail_q);
  assign q_full     = (frames_queued(qhead_q, qtail_q) >= QW'(QUEUE_SLOTS - 1));
  assign len_ok     = (len_q != '0) && (32'(len_q) < 32'(BUF_BYTES));
  assign len_a      = AW'(len_q);
  assign room       = (AW+1)'(BUF_BYTES) - {1'b0, bhead_q};
  assign need       = {1'b0, len_a} + (AW+1)'(btail_q == '0);

  // placement at the head or wrapped to offset zero
  always_comb begin
    fits = 1'b0;
    at   = '0;
    if (bhead_q >= btail_q) begin
      if (room >= need) begin
        fits = 1'b1;
        at   = bhead_q;
      end else if (btail_q > len_a) begin
        fits = 1'b1;
      end
    end else if (btail_q - bhead_q > len_a) begin
      fits = 1'b1;
      at   = bhead_q;
    end
  end

  always_comb begin
    state_d     = state_q;
    qhead_d     = qhead_q;
    qtail_d     = qtail_q;
    bhead_d     = bhead_q;
    btail_d     = btail_q;
    sending_d   = sending_q;
    out_valid_d = out_valid_q && !out_ready_i;
    acc_d       = acc_q;
    woff_d      = woff_q;
    sv_d        = sv_q;
    soff_d      = soff_q;
    slen_d      = slen_q;
    qcnt_d      = qcnt_q;
    free_d      = free_q;
    mem_we      = 1'b0;
    mem_waddr   = qhead_q;
    mem_wdata   = {at, len_a};
    mem_re      = 1'b0;
    mem_raddr   = qtail_q;
    finish      = 1'b0;

    case (state_q)
      txfra_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = txfra_pkg::ST_EXEC;
        end
      end
      txfra_pkg::ST_EXEC: begin
        if (out_free) begin
          acc_d  = 1'b0;
          woff_d = '0;
          sv_d   = 1'b0;
          soff_d = '0;
          slen_d = '0;
          case (act_q)
            txfra_pkg::ACT_ENQUEUE: begin
              if (len_ok && !q_full && fits) begin
                mem_we  = 1'b1;
                bhead_d = ring_wrap({1'b0, at} + {1'b0, len_a});
                qhead_d = slot_next(qhead_q);
                acc_d   = 1'b1;
                woff_d  = OW'(at);
                if (sending_q) begin
                  finish = 1'b1;
                end else if (q_empty) begin
                  // the new frame is the oldest one: forward it
                  sending_d = 1'b1;
                  sv_d      = 1'b1;
                  soff_d    = OW'(at);
                  slen_d    = OW'(len_a);
                  finish    = 1'b1;
                end else begin
                  mem_re  = 1'b1;
                  state_d = txfra_pkg::ST_START;
                end
              end else begin
                finish = 1'b1;
              end
            end
            txfra_pkg::ACT_DONE: begin
              if (q_empty) begin
                sending_d = 1'b0;
                finish    = 1'b1;
              end else begin
                mem_re  = 1'b1;
                state_d = txfra_pkg::ST_RETIRE;
              end
            end
            txfra_pkg::ACT_REFUSE: begin
              if (sending_q && !q_empty) begin
                mem_re  = 1'b1;
                state_d = txfra_pkg::ST_RETIRE;
              end else begin
                finish = 1'b1;
              end
            end
            default: begin
              finish = 1'b1;
            end
          endcase
        end
      end
      txfra_pkg::ST_RETIRE: begin
        btail_d   = ring_wrap({1'b0, rd_off} + {1'b0, rd_len});
        qtail_d   = slot_next(qtail_q);
        sending_d = 1'b0;
        if ((act_q == txfra_pkg::ACT_DONE) && (qhead_q != qtail_d)) begin
          mem_re    = 1'b1;
          mem_raddr = qtail_d;
          state_d   = txfra_pkg::ST_START;
        end else begin
          finish = 1'b1;
        end
      end
      txfra_pkg::ST_START: begin
        sending_d = 1'b1;
        sv_d      = 1'b1;
        soff_d    = OW'(rd_off);
        slen_d    = OW'(rd_len);
        finish    = 1'b1;
      end
      default: begin
        state_d = txfra_pkg::ST_IDLE;
      end
    endcase

    if (finish) begin
      state_d     = txfra_pkg::ST_IDLE;
      out_valid_d = 1'b1;
      qcnt_d      = CW'(frames_queued(qhead_d, qtail_d));
      free_d      = OW'(bytes_free(bhead_d, btail_d));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= txfra_pkg::ST_IDLE;
      qhead_q     <= '0;
      qtail_q     <= '0;
      bhead_q     <= '0;
      btail_q     <= '0;
      sending_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      qhead_q     <= qhead_d;
      qtail_q     <= qtail_d;
      bhead_q     <= bhead_d;
      btail_q     <= btail_d;
      sending_q   <= sending_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      act_q <= txfra_pkg::action_e'(action_i);
      len_q <= frame_length_i;
    end
    acc_q  <= acc_d;
    woff_q <= woff_d;
    sv_q   <= sv_d;
    soff_q <= soff_d;
    slen_q <= slen_d;
    qcnt_q <= qcnt_d;
    free_q <= free_d;
  end

  assign out_valid_o     = out_valid_q;
  assign accepted_o      = acc_q;
  assign write_offset_o  = woff_q;
  assign start_valid_o   = sv_q;
  assign start_offset_o  = soff_q;
  assign start_length_o  = slen_q;
  assign queued_frames_o = qcnt_q;
  assign free_bytes_o    = free_q;

endmodule

/* test/tb_tx_frame_ring_allocator.sv */
// ----------------------------------------------------------------------------
// tb_tx_frame_ring_allocator
// self-checking bench for the transmit frame ring allocator
// ----------------------------------------------------------------------------
// A short table of directed events (rejections, exact fits, wrap to offset
// zero, queue full, refusals and done events on an idle or empty queue) is
// followed by phases of random events that fill, drain or churn the ring.
// An in-bench model of the ring and descriptor queue predicts the status
// beat of every event; beats are compared in order, with random idling on
// both sides except in the last phase.
// ----------------------------------------------------------------------------
module tb_tx_frame_ring_allocator;

  localparam int RING_BYTES = 2048;
  localparam int DESC_SLOTS = 16;
  localparam int unsigned OW = txfra_pkg::OFFSET_W;
  localparam int unsigned CW = txfra_pkg::COUNT_W;
  localparam int unsigned LW = txfra_pkg::LENGTH_W;

  typedef struct packed {
    logic          accepted;
    logic [OW-1:0] write_offset;
    logic          start_valid;
    logic [OW-1:0] start_offset;
    logic [OW-1:0] start_length;
    logic [CW-1:0] queued_frames;
    logic [OW-1:0] free_bytes;
  } frame_result_t;

  typedef struct packed {
    txfra_pkg::action_e act;
    logic [LW-1:0]      len;
    logic [5:0]         reps;
    logic               typed;
    frame_result_t      want;
  } step_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  txfra_pkg::action_e action_i = txfra_pkg::ACT_NOP;
  logic [LW-1:0]      frame_length_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic               accepted_o;
  logic [OW-1:0]      write_offset_o;
  logic               start_valid_o;
  logic [OW-1:0]      start_offset_o;
  logic [OW-1:0]      start_length_o;
  logic [CW-1:0]      queued_frames_o;
  logic [OW-1:0]      free_bytes_o;

  // model state
  int ring_wr = 0;
  int ring_rd = 0;
  int slot_wr = 0;
  int slot_rd = 0;
  bit tx_busy = 1'b0;
  int desc_off [DESC_SLOTS];
  int desc_len [DESC_SLOTS];

  frame_result_t status_due [$];
  frame_result_t got_status;
  frame_result_t want_status;
  int            fails = 0;
  bit            quiet = 1'b0;
  int            rx_hold = 0;

  tx_frame_ring_allocator #(
    .BUF_BYTES  (RING_BYTES),
    .QUEUE_SLOTS(DESC_SLOTS)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .action_i       (action_i),
    .frame_length_i (frame_length_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .accepted_o     (accepted_o),
    .write_offset_o (write_offset_o),
    .start_valid_o  (start_valid_o),
    .start_offset_o (start_offset_o),
    .start_length_o (start_length_o),
    .queued_frames_o(queued_frames_o),
    .free_bytes_o   (free_bytes_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic int frames_held();
    return (slot_wr + DESC_SLOTS - slot_rd) % DESC_SLOTS;
  endfunction

  function automatic void retire_oldest();
    ring_rd = (desc_off[slot_rd] + desc_len[slot_rd]) % RING_BYTES;
    slot_rd = (slot_rd + 1) % DESC_SLOTS;
  endfunction

  function automatic void launch_next(inout frame_result_t r);
    if (tx_busy || slot_wr == slot_rd) return;
    tx_busy = 1'b1;
    r.start_valid = 1'b1;
    r.start_offset = desc_off[slot_rd][OW-1:0];
    r.start_length = desc_len[slot_rd][OW-1:0];
  endfunction

  function automatic frame_result_t apply_event(txfra_pkg::action_e act,
                                                logic [LW-1:0] len_bits);
    frame_result_t r;
    int len;
    int at;
    bit fits;
    r = '0;
    len = int'(len_bits);
    at = 0;
    fits = 1'b0;
    case (act)
      txfra_pkg::ACT_ENQUEUE: begin
        if (len != 0 && len < RING_BYTES && frames_held() < DESC_SLOTS - 1) begin
          if (ring_wr >= ring_rd) begin
            if (RING_BYTES - ring_wr >= len + ((ring_rd == 0) ? 1 : 0)) begin
              at = ring_wr;
              fits = 1'b1;
            end else if (ring_rd > len) begin
              at = 0;
              fits = 1'b1;
            end
          end else if (ring_rd - ring_wr > len) begin
            at = ring_wr;
            fits = 1'b1;
          end
          if (fits) begin
            desc_off[slot_wr] = at;
            desc_len[slot_wr] = len;
            ring_wr = (at + len) % RING_BYTES;
            slot_wr = (slot_wr + 1) % DESC_SLOTS;
            r.accepted = 1'b1;
            r.write_offset = at[OW-1:0];
            launch_next(r);
          end
        end
      end
      txfra_pkg::ACT_DONE: begin
        if (slot_wr != slot_rd) retire_oldest();
        tx_busy = 1'b0;
        launch_next(r);
      end
      txfra_pkg::ACT_REFUSE: begin
        if (tx_busy && slot_wr != slot_rd) begin
          retire_oldest();
          tx_busy = 1'b0;
        end
      end
      default: ;
    endcase
    r.queued_frames = CW'(frames_held());
    if (ring_wr >= ring_rd) r.free_bytes = OW'(RING_BYTES - (ring_wr - ring_rd) - 1);
    else r.free_bytes = OW'(ring_rd - ring_wr - 1);
    return r;
  endfunction

  // lengths biased toward small frames, with some near the largest fit
  function automatic logic [LW-1:0] draw_length();
    int room;
    if (ring_wr >= ring_rd) begin
      room = RING_BYTES - ring_wr - ((ring_rd == 0) ? 1 : 0);
      if (ring_rd - 1 > room) room = ring_rd - 1;
    end else begin
      room = ring_rd - ring_wr - 1;
    end
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return LW'($urandom_range(1, 64));
      6: return LW'($urandom_range(65, 700));
      7: return LW'($urandom_range(0, 4095));
      8: return LW'(room + int'($urandom_range(0, 1)));
      default: return LW'($urandom_range(1, 2047));
    endcase
  endfunction

  function automatic frame_result_t seen(int acc, int wo, int sv, int so, int sl, int q,
                                         int fb);
    frame_result_t r;
    r.accepted = 1'(acc);
    r.write_offset = OW'(wo);
    r.start_valid = 1'(sv);
    r.start_offset = OW'(so);
    r.start_length = OW'(sl);
    r.queued_frames = CW'(q);
    r.free_bytes = OW'(fb);
    return r;
  endfunction

  function automatic step_row_t row(txfra_pkg::action_e a, int l, int n, bit typed,
                                    frame_result_t w);
    step_row_t s;
    s.act = a;
    s.len = LW'(l);
    s.reps = 6'(n);
    s.typed = typed;
    s.want = w;
    return s;
  endfunction

  task automatic offer_event(txfra_pkg::action_e a, logic [LW-1:0] l, bit typed,
                             frame_result_t want);
    frame_result_t predicted;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    action_i       <= a;
    frame_length_i <= l;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predicted = apply_event(a, l);
    status_due.push_back(typed ? want : predicted);
  endtask

  task automatic await_drain();
    in_valid_i <= 1'b0;
    while (status_due.size() != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // result side stalls
  always @(posedge clk_i) begin
    if (rx_hold != 0) rx_hold = rx_hold - 1;
    else if (!quiet && $urandom_range(0, 5) == 0) rx_hold = int'($urandom_range(1, 11));
    out_ready_i <= (rx_hold == 0);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      got_status = {accepted_o, write_offset_o, start_valid_o, start_offset_o,
                    start_length_o, queued_frames_o, free_bytes_o};
      if (status_due.size() == 0) begin
        if (fails < 10) $display("unexpected status beat: acc=%0d wo=%0d", accepted_o,
                                 write_offset_o);
        fails++;
      end else begin
        want_status = status_due.pop_front();
        if (got_status !== want_status) begin
          if (fails < 10) begin
            $display("status mismatch: want acc=%0d wo=%0d sv=%0d so=%0d sl=%0d q=%0d free=%0d",
                     want_status.accepted, want_status.write_offset,
                     want_status.start_valid, want_status.start_offset,
                     want_status.start_length, want_status.queued_frames,
                     want_status.free_bytes);
            $display("                  got  acc=%0d wo=%0d sv=%0d so=%0d sl=%0d q=%0d free=%0d",
                     accepted_o, write_offset_o, start_valid_o, start_offset_o,
                     start_length_o, queued_frames_o, free_bytes_o);
          end
          fails++;
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("tx_frame_ring_allocator regression: fail");
    $finish;
  end

  initial begin
    step_row_t          plan [18];
    frame_result_t      at_rest;
    txfra_pkg::action_e act;
    logic [LW-1:0]      len;
    int                 pick;
    int                 enq_share;
    int                 busy_items;

    at_rest = seen(0, 0, 0, 0, 0, 0, 2047);
    plan = '{
      row(txfra_pkg::ACT_ENQUEUE, 0,    1,  1'b1, at_rest),
      row(txfra_pkg::ACT_ENQUEUE, 2048, 1,  1'b1, at_rest),
      row(txfra_pkg::ACT_ENQUEUE, 4095, 1,  1'b1, at_rest),
      row(txfra_pkg::ACT_DONE,    0,    1,  1'b1, at_rest),
      row(txfra_pkg::ACT_REFUSE,  0,    1,  1'b1, at_rest),
      row(txfra_pkg::ACT_NOP,     4095, 1,  1'b1, at_rest),
      // whole ring in one frame, then no room for a single byte
      row(txfra_pkg::ACT_ENQUEUE, 2047, 1,  1'b1, seen(1, 0, 1, 0, 2047, 1, 0)),
      row(txfra_pkg::ACT_ENQUEUE, 1,    1,  1'b1, seen(0, 0, 0, 0, 0, 1, 0)),
      row(txfra_pkg::ACT_DONE,    0,    1,  1'b1, at_rest),
      // does not fit at the head, wraps to offset zero
      row(txfra_pkg::ACT_ENQUEUE, 2,    1,  1'b1, seen(1, 0, 1, 0, 2, 1, 2044)),
      row(txfra_pkg::ACT_ENQUEUE, 100,  1,  1'b0, '0),
      row(txfra_pkg::ACT_REFUSE,  0,    1,  1'b0, '0),
      row(txfra_pkg::ACT_REFUSE,  0,    1,  1'b0, '0),
      row(txfra_pkg::ACT_ENQUEUE, 40,   1,  1'b0, '0),
      row(txfra_pkg::ACT_ENQUEUE, 24,   13, 1'b0, '0),
      row(txfra_pkg::ACT_ENQUEUE, 24,   1,  1'b0, '0),
      row(txfra_pkg::ACT_REFUSE,  0,    1,  1'b0, '0),
      row(txfra_pkg::ACT_DONE,    0,    1,  1'b0, '0)
    };

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < 18; i++) begin
      repeat (plan[i].reps) offer_event(plan[i].act, plan[i].len, plan[i].typed, plan[i].want);
    end
    await_drain();

    // fill, drain and mixed phases; the last one runs without idling
    for (int ph = 0; ph < 11; ph++) begin
      quiet = (ph == 10);
      enq_share = (ph % 3 == 0) ? 14 : (ph % 3 == 1) ? 6 : 10;
      busy_items = 0;
      while (busy_items < 100) begin
        pick = int'($urandom_range(0, 19));
        if (pick < enq_share) act = txfra_pkg::ACT_ENQUEUE;
        else if (pick < 17) act = txfra_pkg::ACT_DONE;
        else if (pick < 19) act = txfra_pkg::ACT_REFUSE;
        else act = txfra_pkg::ACT_NOP;
        if (act == txfra_pkg::ACT_ENQUEUE) len = draw_length();
        else len = LW'($urandom_range(0, 4095));
        offer_event(act, len, 1'b0, '0);
        if (act != txfra_pkg::ACT_NOP) busy_items++;
      end
      await_drain();
    end

    repeat (12) @(posedge clk_i);
    if (fails == 0) begin
      $display("tx_frame_ring_allocator regression: pass");
    end else begin
      $display("tx_frame_ring_allocator regression: fail");
    end
    $finish;
  end

endmodule
